>>> rtl/core/assert_macros.svh
// Assertion macros shared by the vocoder RTL.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define CVFB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that an expression never holds outside reset.
`define CVFB_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define CVFB_ASSERT(label, prop, msg)
`define CVFB_NEVER(label, expr, msg)
`endif
`endif

>>> rtl/core/cvfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cvfb_pkg;

	localparam int N_BANDS_DEF   = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int FILT_W        = 48;
	localparam int ENV_W         = 32;
	localparam int COEF_W        = 32;
	localparam int SMP_W         = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int MUL_A_W       = 56;
	localparam int MUL_B_W       = 33;
	localparam int MUL_R_W       = 64;
	localparam int WIDE_W        = 66;

	localparam logic [CFG_W-1:0] MAIN_GAIN_RST  = 16'd256;
	localparam logic [CFG_W-1:0] BAND_LEVEL_RST = 16'd32768;
	localparam logic [CFG_W-1:0] LEVEL_ONE      = 16'd32768;

	// coefficient slots within a band
	localparam logic [1:0] COEF_C   = 2'd0;
	localparam logic [1:0] COEF_F   = 2'd1;
	localparam logic [1:0] COEF_ATT = 2'd2;
	localparam logic [1:0] COEF_DEC = 2'd3;

	// filter state slots within a band
	localparam logic [1:0] ST_MID1 = 2'd0;
	localparam logic [1:0] ST_LOW1 = 2'd1;
	localparam logic [1:0] ST_MID2 = 2'd2;
	localparam logic [1:0] ST_LOW2 = 2'd3;

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t W48_MAX = 66'sd140737488355327;
	localparam wide_t W48_MIN = -66'sd140737488355328;
	localparam wide_t W32_MAX = 66'sd2147483647;
	localparam wide_t W32_MIN = -66'sd2147483648;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_COEF   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_COEF,
		OP_CLEAR
	} op_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAIN_GAIN  = 1'b0,
		REG_BAND_LEVEL = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SH_24,
		SH_15,
		SH_17
	} sh_t;

	typedef enum logic [4:0] {
		B_IDLE,
		B_LDC,
		B_LDS,
		B_F1,
		B_H1,
		B_C1,
		B_L1,
		B_F2,
		B_H2,
		B_C2,
		B_L2,
		B_ATT,
		B_WB,
		B_DIF,
		B_ENV,
		B_X,
		B_LVL,
		B_GAIN,
		B_OUT
	} bk_state_t;

	typedef struct packed {
		op_kind_t                  kind;
		logic [3:0]                band;
		logic [1:0]                sel;
		logic signed [COEF_W-1:0]  value;
		logic signed [SMP_W-1:0]   fs;
		logic signed [SMP_W-1:0]   cs;
	} op_t;

	typedef struct packed {
		logic                      start;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
		sh_t                       sh;
	} mul_req_t;

	function automatic logic signed [FILT_W-1:0] sat48(input wide_t v);
		logic signed [FILT_W-1:0] r;
		if (v > W48_MAX) begin
			r = W48_MAX[FILT_W-1:0];
		end else if (v < W48_MIN) begin
			r = W48_MIN[FILT_W-1:0];
		end else begin
			r = v[FILT_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [ENV_W-1:0] sat32(input wide_t v);
		logic signed [ENV_W-1:0] r;
		if (v > W32_MAX) begin
			r = W32_MAX[ENV_W-1:0];
		end else if (v < W32_MIN) begin
			r = W32_MIN[ENV_W-1:0];
		end else begin
			r = v[ENV_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/cvfb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cvfb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one word; the read word is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/cvfb_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module cvfb_mul (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cvfb_pkg::mul_req_t                req,
	output logic                                   done,
	output logic signed [cvfb_pkg::MUL_R_W-1:0]    res
);
	import cvfb_pkg::*;

	localparam int HALF_W = MUL_A_W / 2;
	localparam int PP_W   = HALF_W + MUL_B_W;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                     neg_s1, neg_s2, neg_s3, neg_s4;
	sh_t                      sh_s1, sh_s2, sh_s3, sh_s4;
	logic [MUL_A_W-1:0]       ma_s1;
	logic [MUL_B_W-1:0]       mb_s1, mb_s2;
	logic [HALF_W-1:0]        mhi_s2;
	logic [PP_W-1:0]          plo_s2, plo_s3, phi_s3;
	logic [PROD_W-1:0]        prod_s4;
	logic signed [MUL_R_W-1:0] res_s5;
	logic [PROD_W-1:0]        sft;
	logic [MUL_R_W-2:0]       mag;

	// advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// shift the truncated magnitude, saturate and restore the sign
	always_comb begin
		case (sh_s4)
			SH_15:   sft = prod_s4 >> 15;
			SH_17:   sft = prod_s4 >> 17;
			default: sft = prod_s4 >> 24;
		endcase
		mag = (|sft[PROD_W-1:MUL_R_W-1]) ? {(MUL_R_W-1){1'b1}} : sft[MUL_R_W-2:0];
	end

	// magnitudes, then two partial products, then their sum
	always_ff @(posedge clk) begin
		neg_s1  <= req.a[MUL_A_W-1] ^ req.b[MUL_B_W-1];
		ma_s1   <= req.a[MUL_A_W-1] ? MUL_A_W'(-req.a) : MUL_A_W'(req.a);
		mb_s1   <= req.b[MUL_B_W-1] ? MUL_B_W'(-req.b) : MUL_B_W'(req.b);
		sh_s1   <= req.sh;

		plo_s2  <= PP_W'(ma_s1[HALF_W-1:0]) * PP_W'(mb_s1);
		mhi_s2  <= ma_s1[MUL_A_W-1:HALF_W];
		mb_s2   <= mb_s1;
		neg_s2  <= neg_s1;
		sh_s2   <= sh_s1;

		phi_s3  <= PP_W'(mhi_s2) * PP_W'(mb_s2);
		plo_s3  <= plo_s2;
		neg_s3  <= neg_s2;
		sh_s3   <= sh_s2;

		prod_s4 <= (PROD_W'(phi_s3) << HALF_W) + PROD_W'(plo_s3);
		neg_s4  <= neg_s3;
		sh_s4   <= sh_s3;

		res_s5  <= neg_s4 ? -MUL_R_W'(mag) : MUL_R_W'(mag);
	end

	assign done = vld_s5;
	assign res  = res_s5;

endmodule
`default_nettype wire

>>> rtl/core/cvfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cvfb_front #(
	parameter int N_BANDS = cvfb_pkg::N_BANDS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            cmd,
	input  wire logic [3:0]                            band_index,
	input  wire logic [1:0]                            coef_select,
	input  wire logic signed [cvfb_pkg::COEF_W-1:0]    coef_value,
	input  wire logic signed [cvfb_pkg::SMP_W-1:0]     formant_sample,
	input  wire logic signed [cvfb_pkg::SMP_W-1:0]     carrier_sample,
	output logic                                       push,
	output cvfb_pkg::op_t                              push_op,
	input  wire logic                                  q_full
);
	import cvfb_pkg::*;

	logic     vld_s1;
	op_t      op_s1;
	logic     keep;
	logic     in_range;
	op_kind_t kind;

	assign in_range = 6'(band_index) < 6'(N_BANDS);

	// classify: drop the unused command and writes to absent bands
	always_comb begin
		keep = 1'b0;
		kind = OP_SAMPLE;
		case (cmd_t'(cmd))
			CMD_SAMPLE: begin
				keep = 1'b1;
			end
			CMD_COEF: begin
				kind = OP_COEF;
				keep = in_range;
			end
			CMD_CLEAR: begin
				kind = OP_CLEAR;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall = vld_s1 && q_full;
	assign push     = vld_s1 && !q_full;
	assign push_op  = op_s1;

	// hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1.kind  <= kind;
			op_s1.band  <= band_index;
			op_s1.sel   <= coef_select;
			op_s1.value <= coef_value;
			op_s1.fs    <= formant_sample;
			op_s1.cs    <= carrier_sample;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/cvfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cvfb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cvfb_pkg::op_t  push_op,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output cvfb_pkg::op_t       head_op
);
	import cvfb_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	op_t              ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_op    = ent_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

	`CVFB_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
	`CVFB_ASSERT(a_no_pop_empty, pop |-> head_valid, "pop from empty queue")
	`CVFB_NEVER(a_cnt_range, cnt_q > CNT_W'(QUEUE_DEPTH), "queue count overrun")

endmodule
`default_nettype wire

>>> rtl/core/cvfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cvfb_back #(
	parameter int N_BANDS = cvfb_pkg::N_BANDS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   q_valid,
	input  wire cvfb_pkg::op_t                          q_op,
	output logic                                        q_pop,
	input  wire logic                                   cfg_valid,
	input  wire logic [cvfb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [cvfb_pkg::CFG_W-1:0]             cfg_data,
	output cvfb_pkg::mul_req_t                          mul_req,
	input  wire logic                                   mul_done,
	input  wire logic signed [cvfb_pkg::MUL_R_W-1:0]    mul_res,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [cvfb_pkg::SMP_W-1:0]           out_sample,
	output logic                                        clipped
);
	import cvfb_pkg::*;

	localparam int BAND_W  = (N_BANDS > 1) ? $clog2(N_BANDS) : 1;
	localparam int ADDR_W  = BAND_W + 2;
	localparam int DEPTH_R = 2 ** ADDR_W;
	localparam int ACC_W   = FILT_W + 1 + BAND_W;
	localparam logic signed [MUL_R_W-1:0] OUT_MAX = 64'sd32767;
	localparam logic signed [MUL_R_W-1:0] OUT_MIN = -64'sd32768;

	bk_state_t                 state_q, state_d;
	logic [BAND_W-1:0]         k_q;
	logic [2:0]                j_q;
	logic [1:0]                jm1;
	logic                      bank_q;
	logic                      pend_q;
	logic signed [COEF_W-1:0]  coef_q [4];
	logic signed [FILT_W-1:0]  st_q [4];
	logic signed [FILT_W-1:0]  t_q, h_q, y_q, yc_q, x_q;
	logic signed [MUL_B_W-1:0] d_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ENV_W-1:0]   env_q [N_BANDS];
	logic signed [SMP_W-1:0]   fs_q, cs_q;
	logic [CFG_W-1:0]          gain_q, lvl_q;
	logic [DEPTH_R-1:0]        car_vld_q, frm_vld_q;
	logic                      rvld_q;
	logic signed [SMP_W-1:0]   r_q;
	logic                      rclip_q;
	logic                      out_valid_q;
	logic signed [SMP_W-1:0]   out_sample_q;
	logic                      clipped_q;

	logic                      last_band;
	logic                      out_free;
	logic                      out_load;
	logic                      coef_we;
	logic                      car_we, frm_we;
	logic [ADDR_W-1:0]         coef_waddr;
	logic [ADDR_W-1:0]         st_addr;
	logic [COEF_W-1:0]         coef_rdata;
	logic [FILT_W-1:0]         car_rdata, frm_rdata;
	logic signed [FILT_W-1:0]  st_rd;
	logic signed [FILT_W-1:0]  s_in;
	wide_t                     yw, ayw;

	assign last_band  = k_q == BAND_W'(N_BANDS - 1);
	assign out_free   = !out_valid_q || !out_stall;
	assign jm1        = j_q[1:0] - 2'd1;
	assign st_addr    = {k_q, j_q[1:0]};
	assign coef_waddr = {BAND_W'(q_op.band), q_op.sel};
	assign st_rd      = rvld_q ? signed'(bank_q ? frm_rdata : car_rdata) : '0;
	assign s_in       = bank_q ? (FILT_W'(fs_q) <<< 9) : (FILT_W'(cs_q) <<< 9);
	assign yw         = WIDE_W'(y_q);
	assign ayw        = (yw < 0) ? -yw : yw;

	// coefficient and filter state memories
	cvfb_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH_R)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (q_op.value),
		.raddr (st_addr),
		.rdata (coef_rdata)
	);

	cvfb_ram #(.WIDTH(FILT_W), .DEPTH(DEPTH_R)) u_car_ram (
		.clk   (clk),
		.we    (car_we),
		.waddr (st_addr),
		.wdata (st_q[j_q[1:0]]),
		.raddr (st_addr),
		.rdata (car_rdata)
	);

	cvfb_ram #(.WIDTH(FILT_W), .DEPTH(DEPTH_R)) u_frm_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (st_addr),
		.wdata (st_q[j_q[1:0]]),
		.raddr (st_addr),
		.rdata (frm_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid && q_op.kind == OP_SAMPLE) begin
					state_d = B_LDC;
				end
			end
			B_LDC:  if (j_q == 3'd4) state_d = B_LDS;
			B_LDS:  if (j_q == 3'd4) state_d = B_F1;
			B_F1:   if (mul_done) state_d = B_H1;
			B_H1:   state_d = B_C1;
			B_C1:   if (mul_done) state_d = B_L1;
			B_L1:   state_d = B_F2;
			B_F2:   if (mul_done) state_d = B_H2;
			B_H2:   state_d = B_C2;
			B_C2:   if (mul_done) state_d = B_L2;
			B_L2:   state_d = B_ATT;
			B_ATT:  if (mul_done) state_d = B_WB;
			B_WB: begin
				if (j_q == 3'd3) begin
					state_d = bank_q ? B_DIF : B_LDS;
				end
			end
			B_DIF:  state_d = B_ENV;
			B_ENV:  if (mul_done) state_d = B_X;
			B_X:    if (mul_done) state_d = B_LVL;
			B_LVL: begin
				if (mul_done) begin
					state_d = last_band ? B_GAIN : B_LDC;
				end
			end
			B_GAIN: if (mul_done) state_d = B_OUT;
			B_OUT:  if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs and multiplier operands
	always_comb begin
		q_pop       = 1'b0;
		coef_we     = 1'b0;
		car_we      = 1'b0;
		frm_we      = 1'b0;
		out_load    = 1'b0;
		mul_req     = '0;
		mul_req.sh  = SH_24;
		case (state_q)
			B_IDLE: begin
				q_pop   = q_valid;
				coef_we = q_valid && q_op.kind == OP_COEF;
			end
			B_F1: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(st_q[ST_MID1]);
				mul_req.b     = MUL_B_W'(coef_q[COEF_F]);
			end
			B_F2: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(st_q[ST_MID2]);
				mul_req.b     = MUL_B_W'(coef_q[COEF_F]);
			end
			B_C1, B_C2: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(h_q);
				mul_req.b     = MUL_B_W'(coef_q[COEF_C]);
			end
			B_ATT: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(h_q);
				mul_req.b     = MUL_B_W'(coef_q[COEF_ATT]);
			end
			B_WB: begin
				car_we = !bank_q;
				frm_we = bank_q;
			end
			B_ENV: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(d_q);
				mul_req.b     = MUL_B_W'(coef_q[COEF_DEC]);
			end
			B_X: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(yc_q);
				mul_req.b     = MUL_B_W'(env_q[k_q]);
			end
			B_LVL: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(x_q);
				mul_req.b     = MUL_B_W'(lvl_q);
				mul_req.sh    = SH_15;
			end
			B_GAIN: begin
				mul_req.start = !pend_q;
				mul_req.a     = MUL_A_W'(acc_q);
				mul_req.b     = MUL_B_W'(gain_q);
				mul_req.sh    = SH_17;
			end
			B_OUT: begin
				out_load = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// control state, configuration, envelopes and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			k_q         <= '0;
			j_q         <= '0;
			bank_q      <= 1'b0;
			pend_q      <= 1'b0;
			gain_q      <= MAIN_GAIN_RST;
			lvl_q       <= BAND_LEVEL_RST;
			car_vld_q   <= '0;
			frm_vld_q   <= '0;
			rvld_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N_BANDS; i++) begin
				env_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			rvld_q  <= bank_q ? frm_vld_q[st_addr] : car_vld_q[st_addr];

			if (mul_req.start) begin
				pend_q <= 1'b1;
			end else if (mul_done) begin
				pend_q <= 1'b0;
			end

			// step counter for memory sweeps
			case (state_q)
				B_LDC, B_LDS: j_q <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
				B_WB:         j_q <= (j_q == 3'd3) ? 3'd0 : j_q + 3'd1;
				default:      j_q <= 3'd0;
			endcase

			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_MAIN_GAIN:  gain_q <= cfg_data;
					REG_BAND_LEVEL: lvl_q  <= (cfg_data > LEVEL_ONE) ? LEVEL_ONE : cfg_data;
					default:        gain_q <= gain_q;
				endcase
			end

			if (state_q == B_IDLE && q_valid) begin
				if (q_op.kind == OP_CLEAR) begin
					car_vld_q <= '0;
					frm_vld_q <= '0;
				end else if (q_op.kind == OP_SAMPLE) begin
					k_q    <= '0;
					bank_q <= 1'b0;
				end
			end

			if (car_we) begin
				car_vld_q[st_addr] <= 1'b1;
			end
			if (frm_we) begin
				frm_vld_q[st_addr] <= 1'b1;
			end

			if (state_q == B_WB && j_q == 3'd3 && !bank_q) begin
				bank_q <= 1'b1;
			end

			if (state_q == B_ENV && mul_done) begin
				env_q[k_q] <= sat32(WIDE_W'(env_q[k_q]) + WIDE_W'(mul_res));
			end

			if (state_q == B_LVL && mul_done && !last_band) begin
				k_q    <= k_q + 1'b1;
				bank_q <= 1'b0;
			end

			// hold the result until the consumer takes it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// band datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid && q_op.kind == OP_SAMPLE) begin
					fs_q  <= q_op.fs;
					cs_q  <= q_op.cs;
					acc_q <= '0;
				end
			end
			B_LDC: begin
				if (j_q != 3'd0) begin
					coef_q[jm1] <= coef_rdata;
				end
			end
			B_LDS: begin
				if (j_q != 3'd0) begin
					st_q[jm1] <= st_rd;
				end
			end
			B_F1, B_F2: begin
				if (mul_done) begin
					t_q <= sat48(WIDE_W'(mul_res));
				end
			end
			B_H1: begin
				h_q <= sat48(WIDE_W'(s_in) - WIDE_W'(t_q) - WIDE_W'(st_q[ST_LOW1]));
			end
			B_H2: begin
				h_q <= sat48(WIDE_W'(st_q[ST_LOW1]) - WIDE_W'(t_q)
					- WIDE_W'(st_q[ST_LOW2]));
			end
			B_C1: begin
				if (mul_done) begin
					st_q[ST_MID1] <= sat48(WIDE_W'(st_q[ST_MID1])
						+ WIDE_W'(sat48(WIDE_W'(mul_res))));
				end
			end
			B_C2: begin
				if (mul_done) begin
					st_q[ST_MID2] <= sat48(WIDE_W'(st_q[ST_MID2])
						+ WIDE_W'(sat48(WIDE_W'(mul_res))));
				end
			end
			B_L1: begin
				st_q[ST_LOW1] <= sat48(WIDE_W'(st_q[ST_LOW1]) + WIDE_W'(st_q[ST_MID1]));
			end
			B_L2: begin
				st_q[ST_LOW2] <= sat48(WIDE_W'(st_q[ST_LOW2]) + WIDE_W'(st_q[ST_MID2]));
			end
			B_ATT: begin
				if (mul_done) begin
					y_q <= sat48(WIDE_W'(mul_res));
				end
			end
			B_WB: begin
				if (j_q == 3'd3 && !bank_q) begin
					yc_q <= y_q;
				end
			end
			B_DIF: begin
				d_q <= MUL_B_W'(WIDE_W'(sat32(ayw)) - WIDE_W'(env_q[k_q]));
			end
			B_X: begin
				if (mul_done) begin
					x_q <= sat48(WIDE_W'(mul_res));
				end
			end
			B_LVL: begin
				if (mul_done) begin
					acc_q <= acc_q + ACC_W'(mul_res);
				end
			end
			B_GAIN: begin
				if (mul_done) begin
					if (mul_res > OUT_MAX) begin
						r_q     <= OUT_MAX[SMP_W-1:0];
						rclip_q <= 1'b1;
					end else if (mul_res < OUT_MIN) begin
						r_q     <= OUT_MIN[SMP_W-1:0];
						rclip_q <= 1'b1;
					end else begin
						r_q     <= mul_res[SMP_W-1:0];
						rclip_q <= 1'b0;
					end
				end
			end
			default: begin
				t_q <= t_q;
			end
		endcase
		if (out_load) begin
			out_sample_q <= r_q;
			clipped_q    <= rclip_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign clipped    = clipped_q;

	`CVFB_ASSERT(a_done_pend, mul_done |-> pend_q, "multiplier result without request")
	`CVFB_ASSERT(a_pop_idle, q_pop |-> (state_q == B_IDLE), "queue popped while busy")
	`CVFB_ASSERT(a_start_gap, mul_req.start |=> !mul_done, "multiplier result too early")
	`CVFB_NEVER(a_band_range, k_q > BAND_W'(N_BANDS - 1), "band counter out of range")

endmodule
`default_nettype wire

>>> rtl/core/channel_vocoder_filter_bank_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel vocoder filter bank. Each sample command (cmd 0) runs every band's two
// cascaded state-variable bandpass stages on the carrier and on the formant, updates
// the band envelope and returns one saturated output sample with a clip flag; a
// coefficient write (cmd 1) and a filter clear (cmd 2) return nothing, and cmd 3 is
// dropped. All products go through one shared pipelined multiplier, and band state
// moves through single-port-read memories, so a sample is worked one band after
// another; coefficient writes and clears are handled in the idle state. A four-entry
// command queue lets the input side keep taking commands while a sample is worked on,
// and the output register holds a finished sample while the next one is computed.
// Configuration (index 0 main gain, index 1 band level) is always ready and should be
// written only while the block is idle. Coefficients must be written before use.
module channel_vocoder_filter_bank_unit #(
	parameter int N_BANDS = cvfb_pkg::N_BANDS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            cmd,
	input  wire logic [3:0]                            band_index,
	input  wire logic [1:0]                            coef_select,
	input  wire logic signed [cvfb_pkg::COEF_W-1:0]    coef_value,
	input  wire logic signed [cvfb_pkg::SMP_W-1:0]     formant_sample,
	input  wire logic signed [cvfb_pkg::SMP_W-1:0]     carrier_sample,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [cvfb_pkg::SMP_W-1:0]          out_sample,
	output logic                                       clipped,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [cvfb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [cvfb_pkg::CFG_W-1:0]            cfg_data
);
	import cvfb_pkg::*;

	logic                      push, q_full, q_pop, q_valid;
	op_t                       push_op, q_op;
	mul_req_t                  mul_req;
	logic                      mul_done;
	logic signed [MUL_R_W-1:0] mul_res;

	assign cfg_ready = 1'b1;

	cvfb_front #(.N_BANDS(N_BANDS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.band_index     (band_index),
		.coef_select    (coef_select),
		.coef_value     (coef_value),
		.formant_sample (formant_sample),
		.carrier_sample (carrier_sample),
		.push           (push),
		.push_op        (push_op),
		.q_full         (q_full)
	);

	cvfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_op    (q_op)
	);

	cvfb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.res    (mul_res)
	);

	cvfb_back #(.N_BANDS(N_BANDS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_op       (q_op),
		.q_pop      (q_pop),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mul_req    (mul_req),
		.mul_done   (mul_done),
		.mul_res    (mul_res),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.clipped    (clipped)
	);

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import cvfb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 60000;
	localparam int LONG_HOLD = 20000;
	localparam int SETTLE_CYCLES = 200;
	localparam int NBANDS = N_BANDS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_SAMPLE;
	logic [3:0] band_index = '0;
	logic [1:0] coef_select = COEF_C;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic signed [SMP_W-1:0] formant_sample = '0;
	logic signed [SMP_W-1:0] carrier_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SMP_W-1:0] out_sample;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MAIN_GAIN;
	logic [CFG_W-1:0] cfg_data = '0;

	channel_vocoder_filter_bank_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .band_index(band_index), .coef_select(coef_select),
		.coef_value(coef_value), .formant_sample(formant_sample),
		.carrier_sample(carrier_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_sample(out_sample), .clipped(clipped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		logic signed [SMP_W-1:0] smp;
		logic clip;
	} voc_out_t;

	typedef struct {
		logic [1:0] cmd;
		logic [3:0] band;
		logic [1:0] sel;
		logic signed [COEF_W-1:0] val;
		logic signed [SMP_W-1:0] fs;
		logic signed [SMP_W-1:0] cs;
		bit typed;
		logic signed [SMP_W-1:0] xs;
		logic xc;
	} stim_row_t;

	// predictor state
	longint car_st[NBANDS*4];
	longint frm_st[NBANDS*4];
	longint env_st[NBANDS];
	longint coef_st[NBANDS*4];
	longint gain_q = 256;
	longint level_q = 32768;

	voc_out_t sample_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit rx_busy = 1'b0;
	bit tx_busy = 1'b0;
	stim_row_t dir_rows[$];

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint sat_w(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// exact product, shifted with truncation toward zero, magnitude held to 63 bits
	function automatic longint mul_shift(longint a, longint b, int sh);
		logic [127:0] ua;
		logic [127:0] ub;
		logic [127:0] p;
		logic neg;
		longint mag;
		neg = (a < 0) != (b < 0);
		ua = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
		ub = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
		p = (ua * ub) >> sh;
		if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
		mag = longint'(p[63:0]);
		return neg ? -mag : mag;
	endfunction

	// two cascaded bandpass stages of band k on one bank
	function automatic longint svf_band(bit formant, int k, longint s);
		longint c, f, att, m1, l1, m2, l2, h1, h2;
		c = coef_st[k*4 + COEF_C];
		f = coef_st[k*4 + COEF_F];
		att = coef_st[k*4 + COEF_ATT];
		if (formant) begin
			m1 = frm_st[k*4]; l1 = frm_st[k*4+1]; m2 = frm_st[k*4+2]; l2 = frm_st[k*4+3];
		end else begin
			m1 = car_st[k*4]; l1 = car_st[k*4+1]; m2 = car_st[k*4+2]; l2 = car_st[k*4+3];
		end
		h1 = sat_w(s - sat_w(mul_shift(f, m1, 24), 48) - l1, 48);
		m1 = sat_w(m1 + sat_w(mul_shift(h1, c, 24), 48), 48);
		l1 = sat_w(l1 + m1, 48);
		h2 = sat_w(l1 - sat_w(mul_shift(f, m2, 24), 48) - l2, 48);
		m2 = sat_w(m2 + sat_w(mul_shift(h2, c, 24), 48), 48);
		l2 = sat_w(l2 + m2, 48);
		if (formant) begin
			frm_st[k*4] = m1; frm_st[k*4+1] = l1; frm_st[k*4+2] = m2; frm_st[k*4+3] = l2;
		end else begin
			car_st[k*4] = m1; car_st[k*4+1] = l1; car_st[k*4+2] = m2; car_st[k*4+3] = l2;
		end
		return sat_w(mul_shift(h2, att, 24), 48);
	endfunction

	// advance the predictor by one transfer; returns 1 when a sample comes out
	function automatic bit vocode_step(stim_row_t r, output voc_out_t res);
		longint fs, cs, lvl, acc, yc, yf, ay, x, o;
		res.smp = '0;
		res.clip = 1'b0;
		case (r.cmd)
			CMD_COEF: begin
				coef_st[r.band*4 + r.sel] = longint'(r.val);
				return 1'b0;
			end
			CMD_CLEAR: begin
				foreach (car_st[i]) begin
					car_st[i] = 0;
					frm_st[i] = 0;
				end
				return 1'b0;
			end
			CMD_SAMPLE: begin
				fs = longint'(r.fs) * 512;
				cs = longint'(r.cs) * 512;
				lvl = (level_q > 32768) ? 32768 : level_q;
				acc = 0;
				for (int k = 0; k < NBANDS; k++) begin
					yc = svf_band(1'b0, k, cs);
					yf = svf_band(1'b1, k, fs);
					ay = sat_w((yf < 0) ? -yf : yf, 32);
					env_st[k] = sat_w(env_st[k] +
						mul_shift(ay - env_st[k], coef_st[k*4 + COEF_DEC], 24), 32);
					x = sat_w(mul_shift(yc, env_st[k], 24), 48);
					acc += mul_shift(x, lvl, 15);
				end
				o = mul_shift(acc, gain_q, 17);
				if (o > 32767) begin
					o = 32767; res.clip = 1'b1;
				end else if (o < -32768) begin
					o = -32768; res.clip = 1'b1;
				end
				res.smp = SMP_W'(o);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report(string what, logic signed [SMP_W-1:0] got, logic signed [SMP_W-1:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	function automatic stim_row_t mk(logic [1:0] c, logic [3:0] b, logic [1:0] s,
			logic signed [COEF_W-1:0] v, logic signed [SMP_W-1:0] f,
			logic signed [SMP_W-1:0] cr, bit typed = 1'b0,
			logic signed [SMP_W-1:0] xs = '0, logic xc = 1'b0);
		stim_row_t r;
		r.cmd = c; r.band = b; r.sel = s; r.val = v; r.fs = f; r.cs = cr;
		r.typed = typed; r.xs = xs; r.xc = xc;
		return r;
	endfunction

	// offer one transfer, predict it once taken
	task automatic send(stim_row_t r);
		int gap;
		voc_out_t res;
		gap = tx_busy ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= r.cmd;
		band_index <= r.band;
		coef_select <= r.sel;
		coef_value <= r.val;
		formant_sample <= r.fs;
		carrier_sample <= r.cs;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (vocode_step(r, res)) begin
			if (r.typed) begin
				res.smp = r.xs;
				res.clip = r.xc;
			end
			sample_q.push_back(res);
		end
	endtask

	// stop offering, then wait for every result and let the queue empty
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MAIN_GAIN) gain_q = val;
		else level_q = val;
	endtask

	function automatic logic signed [COEF_W-1:0] rand_coef(logic [1:0] sel);
		if ($urandom_range(0, 9) == 0) return $urandom;
		case (sel)
			COEF_C: return $urandom_range(0, 32'h0060_0000);
			COEF_F: return $urandom_range(0, 32'h0200_0000);
			COEF_ATT: return $urandom_range(0, 32'h0400_0000);
			default: return $urandom_range(0, 32'h0100_0000);
		endcase
	endfunction

	function automatic stim_row_t rand_row();
		int pick;
		logic [1:0] sel;
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 3);
		if (pick < 32)
			return mk(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (pick < 88)
			return mk(CMD_COEF, $urandom, sel, rand_coef(sel), $urandom, $urandom);
		if (pick < 95)
			return mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
		return mk(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// receiver: random stalls, one long hold on request
	initial begin
		int gap;
		voc_out_t w;
		forever begin
			if (hold_req) begin
				gap = LONG_HOLD;
				hold_req = 1'b0;
			end else begin
				gap = rx_busy ? 0 : $urandom_range(0, 12);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			if (sample_q.size() == 0) begin
				report("unexpected out_sample", out_sample, 0);
			end else begin
				w = sample_q.pop_front();
				if (out_sample !== w.smp) report("out_sample", out_sample, w.smp);
				if (clipped !== w.clip) report("clipped", clipped, w.clip);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] gains[6];
		logic [CFG_W-1:0] levels[6];
		foreach (car_st[i]) begin
			car_st[i] = 0; frm_st[i] = 0; coef_st[i] = 0;
		end
		foreach (env_st[i]) env_st[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every coefficient before any sample reads one
		for (int b = 0; b < NBANDS; b++)
			for (int s = 0; s < 4; s++)
				send(mk(CMD_COEF, 4'(b), 2'(s), '0, '0, '0));

		// directed: zero coefficients give silence, then extremes
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 1, 0, 0));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh8000, 16'sh8000, 1, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 0, COEF_C, 32'sh0080_0000, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 0, COEF_F, 32'sh0040_0000, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 0, COEF_ATT, 32'sh0100_0000, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 0, COEF_DEC, 32'sh0100_0000, 0, 0));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh7FFF, 16'sh7FFF));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh8000, 16'sh7FFF));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh7FFF, 16'sh8000));
		dir_rows.push_back(mk(CMD_UNUSED, 15, 3, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF));
		dir_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 15, COEF_C, 32'sh7FFF_FFFF, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 15, COEF_F, 32'sh8000_0000, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 15, COEF_ATT, 32'sh7FFF_FFFF, 0, 0));
		dir_rows.push_back(mk(CMD_COEF, 15, COEF_DEC, 32'sh8000_0000, 0, 0));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh7FFF, 16'sh8000));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh8000, 16'sh7FFF));
		dir_rows.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_SAMPLE, 0, 0, 0, 16'sh1234, 16'shEDCB));
		foreach (dir_rows[i]) send(dir_rows[i]);

		// random phases, each under its own register setting
		gains = '{16'd256, 16'd65535, 16'd0, 16'd1, 16'd4096, 16'd0};
		levels = '{16'd32768, 16'd32768, 16'd0, 16'd65535, 16'd1, 16'd0};
		gains[5] = CFG_W'($urandom);
		levels[5] = CFG_W'($urandom);
		for (int p = 0; p < 6; p++) begin
			drain_and_settle();
			write_reg(REG_MAIN_GAIN, gains[p]);
			write_reg(REG_BAND_LEVEL, levels[p]);
			tx_busy = (p == 2);
			rx_busy = (p == 3);
			if (p == 1) begin
				// hold the output off and keep offering samples until input backs up
				hold_req = 1'b1;
				repeat (10) send(mk(CMD_SAMPLE, 0, 0, 0, $urandom, $urandom));
			end
			for (int n = 0; n < 270; n++) begin
				send(rand_row());
				if (p == 4 && n == 135) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (sample_q.size() != 0) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
		drain_and_settle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/cvfb_pkg.sv
rtl/core/cvfb_ram.sv
rtl/core/cvfb_mul.sv
rtl/core/cvfb_front.sv
rtl/core/cvfb_queue.sv
rtl/core/cvfb_back.sv
rtl/core/channel_vocoder_filter_bank_unit.sv
tb/tb_top.sv
